[sv/psch_pkg.sv]
// ----------------------------------------------------------------------------
// psch_pkg
// Types and codes shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psch_pkg;

	localparam int IdW    = 8;
	localparam int BurstW = 16;
	localparam int PrioW  = 8;

	typedef logic [IdW-1:0]    id_t;
	typedef logic [BurstW-1:0] burst_t;
	typedef logic [PrioW-1:0]  prio_t;

	// input operation codes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_ARRIVE = 1'b1;

	// one ready queue entry, also the shape of the running process
	typedef struct packed {
		id_t    id;
		burst_t burst;
		prio_t  prio;
	} entry_t;

endpackage

[sv/preemptive_priority_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler: ticks run the current process; arrivals start,
// preempt, join a priority-sorted ready queue held in one RAM, or are dropped.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | sink      | in_valid/in_ready  | op, proc_id, burst_len, prio_level
//  out     | source    | out_valid/out_ready| ran_id, cpu_idle, completed, preempted,
//          |           |                    | dropped
//
//  A tick that completes a process while entries wait starts the queue head in
//  ST_POP (one RAM read). An arrival that runs at once or is dropped is handled
//  in ST_IDLE alone; one that joins the queue shifts each less urgent entry back
//  one per cycle in ST_INS_CMP through the single read and write port of the queue RAM.
//  The result is registered at input transfer; a new item is taken while it
//  waits only once the unit is idle and the result is being transferred.
//  Reset is asynchronous and needs no clearing pass; the queue RAM has no reset.

module preemptive_priority_scheduler_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  psch_pkg::id_t    proc_id,
	input  psch_pkg::burst_t burst_len,
	input  psch_pkg::prio_t  prio_level,
	output logic             out_valid,
	input  logic             out_ready,
	output psch_pkg::id_t    ran_id,
	output logic             cpu_idle,
	output logic             completed,
	output logic             preempted,
	output logic             dropped
);
	import psch_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [AW:0]   DEPTH_W  = (AW+1)'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_ADR = AW'(QUEUE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_INS_CMP,
		ST_INS_FIN
	} state_t;

	// logical queue position to RAM address of the circular buffer
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [AW-1:0] lg);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, lg};
		if (s >= DEPTH_W)
			s = s - DEPTH_W;
		return s[AW-1:0];
	endfunction

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   pos_q;
	entry_t          ins_q;
	logic            run_valid_q;
	entry_t          run_q;
	logic            out_valid_q;
	id_t             ran_id_q;
	logic            cpu_idle_q;
	logic            completed_q;
	logic            preempted_q;
	logic            dropped_q;

	entry_t          mem [QUEUE_DEPTH];
	entry_t          rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;

	logic            in_xfer;
	logic            is_tick;
	logic            finish;
	logic            queue_full;
	logic            pos_last;
	entry_t          new_entry;

	id_t             res_ran;
	logic            res_idle;
	logic            res_done;
	logic            res_pre;
	logic            res_drop;

	assign in_ready   = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer    = in_valid && in_ready;
	assign is_tick    = (op == OP_TICK);
	assign finish     = run_valid_q && (run_q.burst <= BurstW'(1));
	assign queue_full = (count_q == FULL_CNT);
	assign pos_last   = (pos_q == AW'(1));
	assign new_entry  = '{id: proc_id, burst: burst_len, prio: prio_level};

	// result of the item on the input
	assign res_ran  = (is_tick && run_valid_q) ? run_q.id : '0;
	assign res_idle = is_tick && !run_valid_q;
	assign res_done = is_tick && finish;
	assign res_pre  = !is_tick && run_valid_q && !queue_full && (prio_level < run_q.prio);
	assign res_drop = !is_tick && run_valid_q && queue_full;

	assign out_valid = out_valid_q;
	assign ran_id    = ran_id_q;
	assign cpu_idle  = cpu_idle_q;
	assign completed = completed_q;
	assign preempted = preempted_q;
	assign dropped   = dropped_q;

	// RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = phys(head_q, pos_q);
		wr_data = ins_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && is_tick && finish && (count_q != '0)) begin
					rd_en   = 1'b1;
					rd_addr = head_q;
				end else if (in_xfer && !is_tick && run_valid_q && !queue_full
						&& (count_q != '0)) begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, AW'(count_q - 1'b1));
				end
			end
			ST_INS_CMP: begin
				wr_en = 1'b1;
				if (rd_data_q.prio > ins_q.prio) begin
					wr_data = rd_data_q;
					if (!pos_last) begin
						rd_en   = 1'b1;
						rd_addr = phys(head_q, pos_q - AW'(2));
					end
				end
			end
			ST_INS_FIN: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			pos_q       <= '0;
			ins_q       <= '0;
			run_valid_q <= 1'b0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
			ran_id_q    <= '0;
			cpu_idle_q  <= 1'b0;
			completed_q <= 1'b0;
			preempted_q <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			if (in_xfer)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ran_id_q    <= res_ran;
						cpu_idle_q  <= res_idle;
						completed_q <= res_done;
						preempted_q <= res_pre;
						dropped_q   <= res_drop;
						if (is_tick) begin
							if (finish) begin
								if (count_q == '0) begin
									run_valid_q <= 1'b0;
									run_q       <= '0;
								end else begin
									state_q <= ST_POP;
								end
							end else if (run_valid_q) begin
								run_q.burst <= run_q.burst - BurstW'(1);
							end
						end else if (!run_valid_q) begin
							run_valid_q <= 1'b1;
							run_q       <= new_entry;
						end else if (!queue_full) begin
							// insert either the displaced process or the arrival
							if (res_pre) begin
								ins_q <= run_q;
								run_q <= new_entry;
							end else begin
								ins_q <= new_entry;
							end
							pos_q   <= AW'(count_q);
							state_q <= (count_q == '0) ? ST_INS_FIN : ST_INS_CMP;
						end
					end
				end
				ST_POP: begin
					run_q   <= rd_data_q;
					head_q  <= (head_q == LAST_ADR) ? '0 : head_q + AW'(1);
					count_q <= count_q - CW'(1);
					state_q <= ST_IDLE;
				end
				ST_INS_CMP: begin
					if (rd_data_q.prio > ins_q.prio) begin
						// shift back one place and look at the next entry
						pos_q <= pos_q - AW'(1);
						if (pos_last)
							state_q <= ST_INS_FIN;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_INS_FIN: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_empty_when_idle_cpu: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !run_valid_q) |-> (count_q == '0))
		else $error("queue holds entries while nothing runs");

	a_pop_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_tick && finish && count_q != '0) |=> (state_q == ST_POP))
		else $error("completion did not start the queue head");

	a_fin_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_FIN) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the queue");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q) |-> queue_full)
		else $error("drop flagged with room in the queue");
`endif

endmodule

[bench/tb_preemptive_priority_scheduler_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_unit
// Self-checking bench for the preemptive priority scheduler. A short table of
// directed items covers idle ticks, completion, zero bursts, preemption, ties
// and drops into a full ready queue. Random ticks and arrivals follow, with random
// idling on both channels but in the last run. Each result is compared field by
// field with its row's value if given, else a cycle-free model of queue and CPU.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_unit;
	import psch_pkg::*;

	localparam int QDEPTH       = 16;
	localparam int DRAIN_CYCLES = 2 * QDEPTH + 8;
	localparam int DIR_N        = 27;

	typedef struct packed {
		id_t  ran;
		logic idle;
		logic done;
		logic pre;
		logic drop;
	} sched_result_t;

	typedef struct packed {
		logic          op;
		id_t           id;
		burst_t        burst;
		prio_t         prio;
		logic          typed;
		sched_result_t res;
	} stim_row_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	logic   op;
	id_t    proc_id;
	burst_t burst_len;
	prio_t  prio_level;
	logic   out_valid;
	logic   out_ready;
	id_t    ran_id;
	logic   cpu_idle;
	logic   completed;
	logic   preempted;
	logic   dropped;

	// scheduler state as the bench sees it
	entry_t      ready_list [QDEPTH];
	int          ready_len = 0;
	logic        cpu_busy  = 1'b0;
	entry_t      cpu_task  = '0;

	sched_result_t pending_results [$];
	stim_row_t     dir_rows [DIR_N];

	int          err_cnt      = 0;
	int          send_gap_pct = 37;
	int          stall_pct    = 52;
	int unsigned hold_req     = 0;

	always #5 clk = ~clk;

	preemptive_priority_scheduler_unit #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.proc_id   (proc_id),
		.burst_len (burst_len),
		.prio_level(prio_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ran_id    (ran_id),
		.cpu_idle  (cpu_idle),
		.completed (completed),
		.preempted (preempted),
		.dropped   (dropped)
	);

	// sorted insert behind every entry of equal or more urgent priority
	function automatic void ready_insert(input entry_t e);
		int pos;
		pos = 0;
		while (pos < ready_len && ready_list[pos].prio <= e.prio)
			pos++;
		for (int k = ready_len; k > pos; k--)
			ready_list[k] = ready_list[k-1];
		ready_list[pos] = e;
		ready_len++;
	endfunction

	function automatic sched_result_t predict_schedule(input logic o, input id_t i,
			input burst_t b, input prio_t p);
		sched_result_t r;
		entry_t        arr;
		r   = '0;
		arr = '{id: i, burst: b, prio: p};
		if (o == OP_TICK) begin
			if (!cpu_busy) begin
				r.idle = 1'b1;
			end else begin
				r.ran = cpu_task.id;
				if (cpu_task.burst <= 1) begin
					r.done = 1'b1;
					if (ready_len == 0) begin
						cpu_busy = 1'b0;
						cpu_task = '0;
					end else begin
						cpu_task = ready_list[0];
						for (int k = 1; k < ready_len; k++)
							ready_list[k-1] = ready_list[k];
						ready_len--;
					end
				end else begin
					cpu_task.burst = cpu_task.burst - 1'b1;
				end
			end
		end else if (!cpu_busy) begin
			cpu_busy = 1'b1;
			cpu_task = arr;
		end else if (ready_len >= QDEPTH) begin
			r.drop = 1'b1;
		end else if (p < cpu_task.prio) begin
			ready_insert(cpu_task);
			cpu_task = arr;
			r.pre    = 1'b1;
		end else begin
			ready_insert(arr);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic check_result();
		sched_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing outstanding", ran_id, 0);
		end else begin
			want = pending_results.pop_front();
			if (ran_id !== want.ran)
				report_mismatch("ran_id", ran_id, want.ran);
			if (cpu_idle !== want.idle)
				report_mismatch("cpu_idle", cpu_idle, want.idle);
			if (completed !== want.done)
				report_mismatch("completed", completed, want.done);
			if (preempted !== want.pre)
				report_mismatch("preempted", preempted, want.pre);
			if (dropped !== want.drop)
				report_mismatch("dropped", dropped, want.drop);
		end
	endtask

	// offer one item, hold it until the transfer, then record what it should give
	task automatic send_item(input logic o, input id_t i, input burst_t b,
			input prio_t p, input logic typed, input sched_result_t want);
		sched_result_t pred;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		proc_id    <= i;
		burst_len  <= b;
		prio_level <= p;
		do
			@(posedge clk);
		while (!in_ready);
		pred = predict_schedule(o, i, b, p);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic send_random(input int n);
		int     arr_pct;
		int     r;
		logic   o;
		id_t    i;
		burst_t b;
		prio_t  p;
		arr_pct = 50;
		for (int k = 0; k < n; k++) begin
			// swing the load so the queue both fills up and drains
			if (k % 50 == 0) begin
				case ($urandom_range(3))
					0: arr_pct = 25;
					1: arr_pct = 45;
					2: arr_pct = 55;
					default: arr_pct = 75;
				endcase
			end
			o = ($urandom_range(99) < arr_pct) ? OP_ARRIVE : OP_TICK;
			i = id_t'($urandom);
			r = $urandom_range(99);
			if (r < 10)
				b = '0;
			else if (r < 80)
				b = burst_t'($urandom_range(6, 1));
			else
				b = burst_t'($urandom_range(40, 7));
			// mostly a narrow band of priorities so ties are common
			r = $urandom_range(99);
			if (r < 60)
				p = prio_t'($urandom_range(7, 0));
			else if (r < 95)
				p = prio_t'($urandom_range(253, 0));
			else
				p = prio_t'($urandom_range(255, 0));
			send_item(o, i, b, p, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = OP_TICK;
		proc_id    = '0;
		burst_len  = '0;
		prio_level = '0;
		out_ready  = 1'b0;
		dir_rows = '{
			'{OP_TICK,   8'h5A, 16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
			'{OP_ARRIVE, 8'hAA, 16'h0002, 8'd100, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1, '{8'hAA, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1, '{8'hAA, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
			// zero burst finishes on its first tick
			'{OP_ARRIVE, 8'h01, 16'h0000, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1, '{8'h01, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{OP_ARRIVE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{OP_ARRIVE, 8'h10, 16'h0003, 8'h01, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
			// equal priority to the running one: queue, do not preempt
			'{OP_ARRIVE, 8'h11, 16'h0001, 8'h01, 1'b0, '0},
			'{OP_ARRIVE, 8'h12, 16'h0000, 8'h01, 1'b0, '0},
			'{OP_ARRIVE, 8'h20, 16'h0004, 8'hFF, 1'b0, '0},
			'{OP_ARRIVE, 8'h21, 16'hAAAA, 8'hFE, 1'b0, '0},
			'{OP_ARRIVE, 8'h22, 16'h0001, 8'h01, 1'b0, '0},
			'{OP_ARRIVE, 8'h23, 16'h0300, 8'h02, 1'b0, '0},
			'{OP_ARRIVE, 8'h24, 16'h0000, 8'h02, 1'b0, '0},
			'{OP_ARRIVE, 8'h25, 16'h0007, 8'h07, 1'b0, '0},
			'{OP_ARRIVE, 8'h26, 16'h0005, 8'h07, 1'b0, '0},
			'{OP_ARRIVE, 8'h27, 16'h0002, 8'hC8, 1'b0, '0},
			'{OP_ARRIVE, 8'h28, 16'h0003, 8'h03, 1'b0, '0},
			'{OP_ARRIVE, 8'h29, 16'h5555, 8'h80, 1'b0, '0},
			'{OP_ARRIVE, 8'h2A, 16'h0001, 8'h40, 1'b0, '0},
			'{OP_ARRIVE, 8'h2B, 16'h0006, 8'hFF, 1'b0, '0},
			'{OP_ARRIVE, 8'h2C, 16'h0001, 8'h01, 1'b0, '0},
			// queue now full: drop, even where the arrival would preempt
			'{OP_ARRIVE, 8'h30, 16'h0005, 8'd50, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
			'{OP_ARRIVE, 8'h31, 16'h0009, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
			'{OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1, '{8'h10, 1'b0, 1'b0, 1'b0, 1'b0}}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[n])
			send_item(dir_rows[n].op, dir_rows[n].id, dir_rows[n].burst,
				dir_rows[n].prio, dir_rows[n].typed, dir_rows[n].res);
		send_random(580);
		send_gap_pct = 52;
		stall_pct    = 37;
		send_random(580);
		// no idling; hold the receiver off first so the input backs up
		send_gap_pct = 0;
		stall_pct    = 0;
		hold_req     = 400;
		send_random(590);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("[preemptive_priority_scheduler_unit] OK");
		else
			$display("[preemptive_priority_scheduler_unit] ERROR");
		$finish;
	end

	// receiver: check each transfer, then decide whether to stall next cycle
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_result();
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[preemptive_priority_scheduler_unit] ERROR");
		$finish;
	end

endmodule
